// ----- sv/uniform_rejection_sampler_13bit_top_assert.svh -----
// Assertion macros for the uniform rejection sampler
`ifndef UNIFORM_REJECTION_SAMPLER_13BIT_TOP_ASSERT_SVH
`define UNIFORM_REJECTION_SAMPLER_13BIT_TOP_ASSERT_SVH

// Condition that must hold at every clock edge outside reset
`define URS13_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// Consequence that must hold in the cycle after the trigger
`define URS13_ASSERT_NEXT(lbl, trig, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/urs13_pkg.sv -----
// Shared types and constants for the uniform rejection sampler
package urs13_pkg;

  localparam int CandBits    = 13;
  localparam int GroupBytes  = 13;
  localparam int BufBits     = 20;
  localparam int HeldW       = 5;
  localparam int PosW        = 4;
  localparam int ModW        = 14;
  localparam int WantW       = 9;
  localparam int ByteW       = 8;
  localparam int LeftW       = 13;
  localparam int IdxW        = 8;
  localparam int CoeffCountDef = 256;

  localparam logic [ModW-1:0]  ModReset  = 14'd7681;
  localparam logic [WantW-1:0] WantReset = 9'd256;

  // register index, taken from paddr[2]
  localparam logic RegModulus = 1'b0;
  localparam logic RegWanted  = 1'b1;

  typedef struct packed {
    logic [ModW-1:0]  modulus;
    logic [WantW-1:0] wanted_count;
  } cfg_t;

  typedef struct packed {
    logic             start_poly;
    logic [ByteW-1:0] data_byte;
    logic [LeftW-1:0] bytes_left;
  } in_item_t;

  typedef struct packed {
    logic                valid;
    logic [CandBits-1:0] coefficient;
    logic [IdxW-1:0]     coeff_index;
    logic                final_coeff;
  } result_t;

endpackage

// ----- sv/urs13_cfg.sv -----
// APB configuration registers: modulus and wanted count
module urs13_cfg (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  output urs13_pkg::cfg_t     cfg_o
);

  logic [urs13_pkg::ModW-1:0]  modulus_q;
  logic [urs13_pkg::WantW-1:0] wanted_q;
  logic                        wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  // byte lane bits of paddr are ignored, registers are word aligned
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      modulus_q <= urs13_pkg::ModReset;
      wanted_q  <= urs13_pkg::WantReset;
    end else if (wr_en) begin
      unique case (paddr[2])
        urs13_pkg::RegModulus: modulus_q <= pwdata[urs13_pkg::ModW-1:0];
        urs13_pkg::RegWanted:  wanted_q  <= pwdata[urs13_pkg::WantW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (paddr[2])
      urs13_pkg::RegModulus: prdata = 32'(modulus_q);
      urs13_pkg::RegWanted:  prdata = 32'(wanted_q);
      default: prdata = '0;
    endcase
  end

  assign cfg_o.modulus      = modulus_q;
  assign cfg_o.wanted_count = wanted_q;

endmodule

// ----- sv/urs13_core.sv -----
// Bit unpacking, rejection test and polynomial state
module urs13_core #(
  parameter int COEFF_COUNT = urs13_pkg::CoeffCountDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 fire_i,
  input  urs13_pkg::in_item_t  item_i,
  input  urs13_pkg::cfg_t      cfg_i,
  output urs13_pkg::result_t   res_o
);

  // count never passes min(wanted_count, COEFF_COUNT) <= 511
  localparam int CntW = (COEFF_COUNT < 512) ? $clog2(COEFF_COUNT + 1) : urs13_pkg::WantW;

  logic [urs13_pkg::BufBits-1:0] buf_q, buf_d, buf_c, buf_new, byte_sh;
  logic [urs13_pkg::HeldW-1:0]   held_q, held_d, held_c, held_new;
  logic [urs13_pkg::PosW-1:0]    pos_q, pos_d, pos_c, pos_new;
  logic [CntW-1:0]               cnt_q, cnt_d, cnt_c, cnt_inc, bound;
  logic [CntW+urs13_pkg::IdxW-1:0] idx_ext;
  logic [urs13_pkg::CandBits-1:0] cand;
  logic                          done, skip, have, take;

  always_comb begin
    cnt_c  = item_i.start_poly ? '0 : cnt_q;
    buf_c  = item_i.start_poly ? '0 : buf_q;
    held_c = item_i.start_poly ? '0 : held_q;
    pos_c  = item_i.start_poly ? '0 : pos_q;

    if (int'(cfg_i.wanted_count) > COEFF_COUNT) begin
      bound = CntW'(COEFF_COUNT);
    end else begin
      bound = CntW'(cfg_i.wanted_count);
    end

    done = cnt_c >= bound;
    skip = done || ((pos_c == '0) &&
           (item_i.bytes_left < urs13_pkg::LeftW'(urs13_pkg::GroupBytes)));

    byte_sh  = urs13_pkg::BufBits'(item_i.data_byte) << held_c;
    buf_new  = buf_c | byte_sh;
    held_new = held_c + urs13_pkg::HeldW'(urs13_pkg::ByteW);
    pos_new  = (pos_c == urs13_pkg::PosW'(urs13_pkg::GroupBytes - 1)) ? '0
             : pos_c + urs13_pkg::PosW'(1);
    have     = held_new >= urs13_pkg::HeldW'(urs13_pkg::CandBits);
    cand     = buf_new[urs13_pkg::CandBits-1:0];
    take     = !skip && have && ({1'b0, cand} < cfg_i.modulus);
    cnt_inc  = cnt_c + CntW'(1);

    buf_d  = buf_c;
    held_d = held_c;
    pos_d  = pos_c;
    cnt_d  = cnt_c;
    if (!skip) begin
      pos_d = pos_new;
      if (have) begin
        buf_d  = buf_new >> urs13_pkg::CandBits;
        held_d = held_new - urs13_pkg::HeldW'(urs13_pkg::CandBits);
      end else begin
        buf_d  = buf_new;
        held_d = held_new;
      end
      if (take) begin
        cnt_d = cnt_inc;
      end
    end

    idx_ext           = {{urs13_pkg::IdxW{1'b0}}, cnt_c};
    res_o.valid       = take;
    res_o.coefficient = cand;
    res_o.coeff_index = idx_ext[urs13_pkg::IdxW-1:0];
    res_o.final_coeff = cnt_inc == bound;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buf_q  <= '0;
      held_q <= '0;
      pos_q  <= '0;
      cnt_q  <= '0;
    end else if (fire_i) begin
      buf_q  <= buf_d;
      held_q <= held_d;
      pos_q  <= pos_d;
      cnt_q  <= cnt_d;
    end
  end

endmodule

// ----- sv/uniform_rejection_sampler_13bit_top.sv -----
// Top level of the 13-bit uniform rejection sampler
//
//  channel   dir  handshake                 payload
//  s_axis    in   s_axis_tvalid/tready      tdata: data_byte, bytes_left; tuser: start_poly
//  m_axis    out  m_axis_tvalid/tready      tdata: coefficient, coeff_index; tlast: final
//  apb       in   psel/penable, pready = 1  modulus (0x0), wanted_count (0x4)
//
// One byte per cycle sustained while the output is not stalled.
// Input register feeds one pass of unpack/compare logic into the output register.
// Output stall backs up through the input register; both stages hold their data.
// Reset clears valids and core state (no clearing pass), not data; cfg resets 7681, 256.
module uniform_rejection_sampler_13bit_top #(
  parameter int COEFF_COUNT = urs13_pkg::CoeffCountDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // [7:0] data_byte, [20:8] bytes_left, rest zero
  input  logic [0:0]  s_axis_tuser,   // [0] start_poly
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [12:0] coefficient, [20:13] coeff_index, rest zero
  output logic        m_axis_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  `include "uniform_rejection_sampler_13bit_top_assert.svh"

  urs13_pkg::cfg_t     cfg;
  urs13_pkg::in_item_t in_q, in_d;
  urs13_pkg::result_t  res, out_q;
  logic                in_valid_q, out_valid_q;
  logic                out_free, proc_fire, in_xfer;

  urs13_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  assign out_free      = !out_valid_q || m_axis_tready;
  assign proc_fire     = in_valid_q && out_free;
  assign s_axis_tready = !in_valid_q || proc_fire;
  assign in_xfer       = s_axis_tvalid && s_axis_tready;

  always_comb begin
    in_d.start_poly = s_axis_tuser[0];
    in_d.data_byte  = s_axis_tdata[7:0];
    in_d.bytes_left = s_axis_tdata[20:8];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      in_q <= in_d;
    end
  end

  urs13_core #(
    .COEFF_COUNT (COEFF_COUNT)
  ) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (proc_fire),
    .item_i (in_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= proc_fire && res.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc_fire && res.valid) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'b000, out_q.coeff_index, out_q.coefficient};
  assign m_axis_tlast  = out_q.final_coeff;

  `URS13_ASSERT_ALWAYS(a_empty_in_ready, in_valid_q || s_axis_tready,
    "input stage empty but not ready")
  `URS13_ASSERT_NEXT(a_result_lands, proc_fire && res.valid, out_valid_q,
    "accepted coefficient did not reach output register")
  `URS13_ASSERT_ALWAYS(a_full_in_drains, !(in_xfer && in_valid_q) || proc_fire,
    "input register overwritten without processing")

endmodule

// ----- bench/urs13_coeff_checker.sv -----
`timescale 1ns / 100ps
// Checker for the 13-bit rejection sampler: predicts each output transfer and compares it
module urs13_coeff_checker #(
  parameter int COEFF_COUNT = urs13_pkg::CoeffCountDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // [7:0] data_byte, [20:8] bytes_left, rest zero
  input  logic [0:0]  s_axis_tuser,   // [0] start_poly
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [23:0] m_axis_tdata,   // [12:0] coefficient, [20:13] coeff_index, rest zero
  input  logic        m_axis_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  input  logic        drain_done_i,
  output int          pending_o,
  output int          fail_count_o
);
  import urs13_pkg::*;

  typedef struct packed {
    logic [CandBits-1:0] coefficient;
    logic [IdxW-1:0]     coeff_index;
    logic                final_coeff;
  } coeff_t;

  logic [ModW-1:0]    modulus_q;
  logic [WantW-1:0]   wanted_q;
  logic [BufBits-1:0] bit_buf;
  logic [HeldW-1:0]   bits_held;
  logic [PosW-1:0]    grp_pos;
  logic [WantW-1:0]   accepted;
  coeff_t             pending_coeffs[$];
  bit                 leftovers_checked;

  initial begin
    fail_count_o      = 0;
    pending_o         = 0;
    leftovers_checked = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    if (fail_count_o < 40) $display("%0t ns mismatch: %s", $time, msg);
    fail_count_o++;
  endtask

  task automatic clear_poly();
    bit_buf   = '0;
    bits_held = '0;
    grp_pos   = '0;
    accepted  = '0;
  endtask

  // one byte through the unpacker; queues the coefficient it yields, if any
  task automatic sample_byte(input in_item_t item);
    int                  bound;
    logic [CandBits-1:0] cand;
    coeff_t              res;
    if (item.start_poly) clear_poly();
    bound = (int'(wanted_q) > COEFF_COUNT) ? COEFF_COUNT : int'(wanted_q);
    if (int'(accepted) >= bound) return;
    if (grp_pos == '0 && item.bytes_left < LeftW'(GroupBytes)) return;
    bit_buf   = bit_buf | (BufBits'(item.data_byte) << bits_held);
    bits_held = bits_held + HeldW'(ByteW);
    grp_pos   = (grp_pos == PosW'(GroupBytes - 1)) ? '0 : grp_pos + 1'b1;
    if (bits_held < HeldW'(CandBits)) return;
    cand      = bit_buf[CandBits-1:0];
    bit_buf   = bit_buf >> CandBits;
    bits_held = bits_held - HeldW'(CandBits);
    if (ModW'(cand) >= modulus_q) return;
    res.coefficient = cand;
    res.coeff_index = accepted[IdxW-1:0];
    accepted        = accepted + 1'b1;
    res.final_coeff = (int'(accepted) == bound);
    pending_coeffs.push_back(res);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    coeff_t got;
    coeff_t want;
    if (!rst_ni) begin
      modulus_q = ModReset;
      wanted_q  = WantReset;
      clear_poly();
      pending_coeffs.delete();
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = '{m_axis_tdata[12:0], m_axis_tdata[20:13], m_axis_tlast};
        if (pending_coeffs.size() == 0) begin
          report_mismatch($sformatf("coefficient %0d index %0d with none expected",
                                    got.coefficient, got.coeff_index));
        end else begin
          want = pending_coeffs.pop_front();
          if (got.coefficient != want.coefficient)
            report_mismatch($sformatf("coefficient %0d, expected %0d",
                                      got.coefficient, want.coefficient));
          if (got.coeff_index != want.coeff_index)
            report_mismatch($sformatf("coeff_index %0d, expected %0d",
                                      got.coeff_index, want.coeff_index));
          if (got.final_coeff != want.final_coeff)
            report_mismatch($sformatf("final flag %0b, expected %0b (index %0d)",
                                      got.final_coeff, want.final_coeff, want.coeff_index));
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        sample_byte('{s_axis_tuser[0], s_axis_tdata[7:0], s_axis_tdata[20:8]});
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == RegModulus) modulus_q = pwdata[ModW-1:0];
        else wanted_q = pwdata[WantW-1:0];
      end
      if (drain_done_i && !leftovers_checked) begin
        leftovers_checked = 1'b1;
        if (pending_coeffs.size() != 0)
          report_mismatch($sformatf("%0d expected coefficients never arrived",
                                    pending_coeffs.size()));
      end
    end
    pending_o = pending_coeffs.size();
  end

endmodule

// ----- bench/tb_uniform_rejection_sampler_13bit_top.sv -----
`timescale 1ns / 100ps
// Testbench top for the 13-bit rejection sampler: clock, reset, stimulus and verdict
module tb_uniform_rejection_sampler_13bit_top;
  import urs13_pkg::*;

  localparam int CoeffCount = CoeffCountDef;
  localparam int CycleLimit = 400000;
  localparam int NumPhases  = 8;
  localparam logic [2:0] AddrModulus = {RegModulus, 2'b00};
  localparam logic [2:0] AddrWanted  = {RegWanted, 2'b00};

  typedef enum int {IdleNone, IdleSend, IdleRecv, IdleBoth} idle_mode_e;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata  = '0;   // [7:0] data_byte, [20:8] bytes_left, rest zero
  logic [0:0]  s_axis_tuser  = '0;   // [0] start_poly
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;         // [12:0] coefficient, [20:13] coeff_index, rest zero
  logic        m_axis_tlast;
  logic        psel          = 1'b0;
  logic        penable       = 1'b0;
  logic        pwrite        = 1'b0;
  logic [2:0]  paddr         = '0;
  logic [31:0] pwdata        = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        drain_done    = 1'b0;
  int          pending;
  int          fail_count;
  int          cycles        = 0;
  idle_mode_e  idle_mode     = IdleNone;

  int phase_mod  [NumPhases] = '{7681, 16383, 8192, 0, 1, 4096, 5000, 8191};
  int phase_want [NumPhases] = '{256, 511, 17, 3, 9, 1, 0, 40};
  int phase_items[NumPhases] = '{200, 220, 160, 60, 120, 160, 40, 240};

  uniform_rejection_sampler_13bit_top #(.COEFF_COUNT(CoeffCount)) dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  urs13_coeff_checker #(.COEFF_COUNT(CoeffCount)) checker_i (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast,
    .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .drain_done_i(drain_done), .pending_o(pending), .fail_count_o(fail_count)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    case (idle_mode)
      IdleRecv: m_axis_tready <= ($urandom_range(99) >= 74);
      IdleBoth: m_axis_tready <= ($urandom_range(99) >= 24);
      default:  m_axis_tready <= 1'b1;
    endcase
  end

  function automatic int send_idle_pct();
    case (idle_mode)
      IdleSend: return 74;
      IdleBoth: return 24;
      default:  return 0;
    endcase
  endfunction

  task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic send_byte(input in_item_t item);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {3'b000, item.bytes_left, item.data_byte};
    s_axis_tuser  <= item.start_poly;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct()) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
  endtask

  // lets the pipeline empty before a register write
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  function automatic logic [ByteW-1:0] rand_byte();
    case ($urandom_range(15))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return ByteW'($urandom_range(255));
    endcase
  endfunction

  function automatic int pick_buffer();
    case ($urandom_range(3))
      0:       return 168;
      1:       return $urandom_range(40, 13);
      2:       return $urandom_range(12, 1);
      default: return $urandom_range(8191, 13);
    endcase
  endfunction

  // mostly polynomials with buffers counting down, some noise with random fields
  task automatic drive_random_bytes(input int count);
    int       sent;
    int       len;
    int       remaining;
    in_item_t item;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(9) == 0) begin
        len = $urandom_range(8, 1);
        if (len > count - sent) len = count - sent;
        for (int j = 0; j < len; j++) begin
          item.start_poly = ($urandom_range(7) == 0);
          item.data_byte  = ByteW'($urandom);
          item.bytes_left = LeftW'($urandom);
          send_byte(item);
        end
      end else begin
        len       = $urandom_range(160, 20);
        if (len > count - sent) len = count - sent;
        remaining = pick_buffer();
        for (int j = 0; j < len; j++) begin
          item.start_poly = (j == 0);
          item.data_byte  = rand_byte();
          item.bytes_left = ($urandom_range(39) == 0) ? LeftW'($urandom) : LeftW'(remaining);
          send_byte(item);
          remaining--;
          if (remaining == 0) remaining = pick_buffer();
        end
      end
      sent += len;
    end
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // short buffers, a group across buffer changes, then done and restart
    apb_write(AddrModulus, 32'd16383);
    apb_write(AddrWanted, 32'd2);
    send_byte('{1'b1, 8'hFF, 13'd0});
    send_byte('{1'b0, 8'h00, 13'd12});
    send_byte('{1'b1, 8'hFF, 13'd8191});
    send_byte('{1'b0, 8'hFF, 13'd1});
    send_byte('{1'b0, 8'h00, 13'd0});
    send_byte('{1'b0, 8'hAA, 13'd13});
    send_byte('{1'b0, 8'h55, 13'd200});
    send_byte('{1'b1, 8'h00, 13'd13});
    wait_idle();
    apb_write(AddrWanted, 32'd256);
    send_byte('{1'b1, 8'h00, 13'd13});
    for (int j = 12; j >= 1; j--)
      send_byte('{1'b0, (j % 2) ? 8'hFF : 8'h00, LeftW'(j)});
    send_byte('{1'b0, 8'h5A, 13'd5});
    wait_idle();

    for (int p = 0; p < NumPhases; p++) begin
      apb_write(AddrModulus, 32'(phase_mod[p]));
      apb_write(AddrWanted, 32'(phase_want[p]));
      idle_mode = idle_mode_e'(p % 4);
      drive_random_bytes(phase_items[p]);
      wait_idle();
    end

    idle_mode = IdleNone;
    repeat (10) @(negedge clk_i);
    drain_done <= 1'b1;
    repeat (3) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
